// ----- src/accel_gravity_scale_calibrator_defines.svh -----
// assertion macros for the gravity scale calibrator
// expects clk and rst_n in the scope of use
`ifndef ACCEL_GRAVITY_SCALE_CALIBRATOR_DEFINES_SVH
`define ACCEL_GRAVITY_SCALE_CALIBRATOR_DEFINES_SVH

// same-cycle implication
`define AGSC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AGSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/agsc_pkg.sv -----
// shared constants, register indexes, state and command types
// no dependencies
`timescale 1ns / 1ps

package agsc_pkg;

    localparam logic [15:0] SETTLE_SAMPLES = 16'd64;
    localparam logic [23:0] TARGET_SAMPLES = 24'd512;
    localparam logic [15:0] MIN_MAG        = 16'd52;
    localparam logic [17:0] SCALE_MAX      = 18'h3FFFF;
    localparam logic [17:0] SCALE_ONE      = 18'd65536;
    localparam logic [23:0] COUNT_MAX      = 24'hFFFFFF;
    localparam logic [15:0] SETTLE_MAX     = 16'hFFFF;
    localparam logic [15:0] SPEED_RESET    = 16'd128;
    localparam logic [14:0] GRAVITY_RESET  = 15'd5021;

    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = 40;

    localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd6;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQR,
        S_ACC,
        S_SQRT_INIT,
        S_SQRT,
        S_MAG,
        S_SCL_START,
        S_SCL_WAIT,
        S_MUL,
        S_RND,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
    } cfg_wr_t;

    typedef struct packed {
        logic load;
        logic update;
        logic div_start;
        logic div_scale;
        logic mul_sqr;
        logic acc_add;
        logic sqrt_init;
        logic sqrt_step;
        logic mag_load;
        logic scale_load;
        logic mul_out;
        logic out_store;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic cal_req;
        logic div_done;
        logic last_axis;
        logic sqrt_done;
        logic mag_ok;
        logic res_busy;
    } dp_status_t;

endpackage

// ----- src/agsc_if.sv -----
// sample, result and configuration channel interfaces
// uses agsc_pkg for the register index width
`timescale 1ns / 1ps

interface agsc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        ground_speed;

    modport source (output valid, accel_x, accel_y, accel_z, ground_speed, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, ground_speed, output ready);
endinterface

interface agsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               is_calibrated;
    logic [15:0]        gravity_seen;
    logic [17:0]        scale_now;

    modport source (output valid, out_x, out_y, out_z, is_calibrated, gravity_seen,
                    scale_now, input ready);
    modport sink   (input valid, out_x, out_y, out_z, is_calibrated, gravity_seen,
                    scale_now, output ready);
endinterface

interface agsc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [agsc_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/agsc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// uses agsc_pkg for the step count
`timescale 1ns / 1ps

module agsc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [39:0] quotient
);

    logic [23:0] rem_reg, rem_next;
    logic [39:0] quo_reg, quo_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[39]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'(agsc_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = 24'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[23:0];
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = !busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/agsc_dp.sv -----
// datapath: config and calibration state, mean, square root, scale, output stage
// uses agsc_pkg, agsc_div and the assertion macros
`timescale 1ns / 1ps
`include "accel_gravity_scale_calibrator_defines.svh"

module agsc_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  agsc_pkg::cfg_wr_t       cfg_wr,
    input  logic signed [15:0]      accel_x,
    input  logic signed [15:0]      accel_y,
    input  logic signed [15:0]      accel_z,
    input  logic [15:0]             ground_speed,
    input  agsc_pkg::dp_cmd_t       cmd,
    output agsc_pkg::dp_status_t    status,
    input  logic                    res_ready,
    output logic                    res_valid,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic signed [15:0]      out_z,
    output logic                    is_calibrated,
    output logic [15:0]             gravity_seen,
    output logic [17:0]             scale_now
);

    // configuration
    logic               bypass_reg;
    logic               auto_en_reg;
    logic signed [15:0] off_reg [3];
    logic [15:0]        speed_lim_reg;
    logic [14:0]        grav_tgt_reg;

    // calibration state
    logic               done_reg;
    logic [15:0]        settle_cnt_reg;
    logic [23:0]        sample_cnt_reg;
    logic signed [39:0] sum_reg [3];
    logic [17:0]        scale_reg;
    logic [15:0]        mag_reg;

    // working registers
    logic signed [15:0] raw_reg [3];
    logic [15:0]        speed_reg;
    logic [1:0]         axis_reg;
    logic               neg_reg;
    logic signed [37:0] mul_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        sq_v_reg;
    logic [31:0]        sq_res_reg;
    logic [31:0]        sq_bit_reg;
    logic signed [15:0] pend_reg [3];

    // result register
    logic               res_valid_reg;
    logic signed [15:0] res_out_reg [3];
    logic               res_cal_reg;
    logic [15:0]        res_mag_reg;
    logic [17:0]        res_scale_reg;

    // update decisions
    logic        upd_on;
    logic        still;
    logic [15:0] settle_inc;
    logic [23:0] cnt_inc;
    logic        collect;

    // divider
    logic        div_start;
    logic [39:0] div_dividend;
    logic [23:0] div_divisor;
    logic        div_done;
    logic [39:0] div_quo;
    logic [39:0] sum_abs;

    // multiplier and misc
    logic signed [16:0] mean_val;
    logic signed [18:0] mul_a;
    logic signed [18:0] mul_b;
    logic [32:0]        sq_sum;
    logic [15:0]        mag_sat;
    logic signed [37:0] rnd_val;
    logic signed [23:0] scaled;
    logic signed [23:0] diff;
    logic signed [15:0] sat_val;

    always_comb
    begin
        upd_on     = !bypass_reg && auto_en_reg && !done_reg;
        still      = speed_reg < speed_lim_reg;
        settle_inc = (settle_cnt_reg < agsc_pkg::SETTLE_MAX) ? settle_cnt_reg + 16'd1
                                                             : settle_cnt_reg;
        collect    = settle_inc >= agsc_pkg::SETTLE_SAMPLES;
        cnt_inc    = (sample_cnt_reg < agsc_pkg::COUNT_MAX) ? sample_cnt_reg + 24'd1
                                                            : sample_cnt_reg;
    end

    // divider operand select
    always_comb
    begin
        sum_abs = sum_reg[axis_reg][39] ? 40'(-sum_reg[axis_reg]) : 40'(sum_reg[axis_reg]);
        if (cmd.div_scale)
        begin
            div_dividend = {9'd0, grav_tgt_reg, 16'd0} + {25'd0, mag_reg[15:1]};
            div_divisor  = {8'd0, mag_reg};
        end
        else
        begin
            div_dividend = sum_abs + {17'd0, sample_cnt_reg[23:1]};
            div_divisor  = sample_cnt_reg;
        end
        div_start = cmd.div_start;
    end

    agsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // shared multiplier operands
    always_comb
    begin
        mean_val = neg_reg ? -$signed({1'b0, div_quo[15:0]}) : $signed({1'b0, div_quo[15:0]});
        if (cmd.mul_out)
        begin
            mul_a = 19'(raw_reg[axis_reg]);
            mul_b = $signed({1'b0, scale_reg});
        end
        else
        begin
            mul_a = 19'(mean_val);
            mul_b = 19'(mean_val);
        end
    end

    // square root step and output rounding
    always_comb
    begin
        sq_sum  = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        mag_sat = (sq_res_reg[31:16] != 16'd0) ? 16'hFFFF : sq_res_reg[15:0];
        rnd_val = (mul_reg + 38'sd32768) >>> 16;
        scaled  = done_reg ? rnd_val[23:0] : 24'(raw_reg[axis_reg]);
        diff    = scaled - 24'(off_reg[axis_reg]);
        if (diff > 24'sd32767)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (diff < -24'sd32768)
        begin
            sat_val = -16'sh8000;
        end
        else
        begin
            sat_val = diff[15:0];
        end
    end

    always_comb
    begin
        status.cal_req   = upd_on && still && collect && (cnt_inc >= agsc_pkg::TARGET_SAMPLES);
        status.div_done  = div_done;
        status.last_axis = axis_reg == agsc_pkg::AXIS_LAST;
        status.sqrt_done = sq_bit_reg == 32'd0;
        status.mag_ok    = mag_sat >= agsc_pkg::MIN_MAG;
        status.res_busy  = res_valid_reg && !res_ready;
    end

    // control-relevant state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg     <= 1'b0;
            auto_en_reg    <= 1'b1;
            off_reg[0]     <= '0;
            off_reg[1]     <= '0;
            off_reg[2]     <= '0;
            speed_lim_reg  <= agsc_pkg::SPEED_RESET;
            grav_tgt_reg   <= agsc_pkg::GRAVITY_RESET;
            done_reg       <= 1'b0;
            settle_cnt_reg <= '0;
            sample_cnt_reg <= '0;
            sum_reg[0]     <= '0;
            sum_reg[1]     <= '0;
            sum_reg[2]     <= '0;
            scale_reg      <= agsc_pkg::SCALE_ONE;
            mag_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr.valid)
            begin
                case (cfg_wr.index)
                    agsc_pkg::REG_BYPASS:   bypass_reg <= cfg_wr.data[0];
                    agsc_pkg::REG_AUTO_EN:
                    begin
                        auto_en_reg <= cfg_wr.data[0];
                        if (!cfg_wr.data[0])
                        begin
                            settle_cnt_reg <= '0;
                            sample_cnt_reg <= '0;
                            sum_reg[0]     <= '0;
                            sum_reg[1]     <= '0;
                            sum_reg[2]     <= '0;
                        end
                    end
                    agsc_pkg::REG_OFFSET_X: off_reg[0] <= cfg_wr.data;
                    agsc_pkg::REG_OFFSET_Y: off_reg[1] <= cfg_wr.data;
                    agsc_pkg::REG_OFFSET_Z: off_reg[2] <= cfg_wr.data;
                    agsc_pkg::REG_SPEED:    speed_lim_reg <= cfg_wr.data;
                    agsc_pkg::REG_GRAVITY:  grav_tgt_reg <= cfg_wr.data[14:0];
                    default:                ;
                endcase
            end

            if (cmd.update && upd_on)
            begin
                if (still)
                begin
                    settle_cnt_reg <= settle_inc;
                    if (collect && (sample_cnt_reg < agsc_pkg::COUNT_MAX))
                    begin
                        sum_reg[0]     <= sum_reg[0] + 40'(raw_reg[0]);
                        sum_reg[1]     <= sum_reg[1] + 40'(raw_reg[1]);
                        sum_reg[2]     <= sum_reg[2] + 40'(raw_reg[2]);
                        sample_cnt_reg <= cnt_inc;
                    end
                end
                else if (settle_cnt_reg != 16'd0)
                begin
                    settle_cnt_reg <= '0;
                    sample_cnt_reg <= '0;
                    sum_reg[0]     <= '0;
                    sum_reg[1]     <= '0;
                    sum_reg[2]     <= '0;
                end
            end

            if (cmd.mag_load)
            begin
                mag_reg <= mag_sat;
            end

            if (cmd.scale_load)
            begin
                scale_reg  <= (div_quo > 40'(agsc_pkg::SCALE_MAX)) ? agsc_pkg::SCALE_MAX
                                                                   : div_quo[17:0];
                done_reg   <= 1'b1;
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
                sum_reg[2] <= '0;
            end

            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg[0] <= accel_x;
            raw_reg[1] <= accel_y;
            raw_reg[2] <= accel_z;
            speed_reg  <= ground_speed;
        end
        if (cmd.update || cmd.sqrt_init)
        begin
            axis_reg <= '0;
        end
        else if (cmd.acc_add || cmd.out_store)
        begin
            axis_reg <= axis_reg + 2'd1;
        end
        if (cmd.update)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + mul_reg[31:0];
        end
        if (cmd.div_start && !cmd.div_scale)
        begin
            neg_reg <= sum_reg[axis_reg][39];
        end
        if (cmd.mul_sqr || cmd.mul_out)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.sqrt_init)
        begin
            sq_v_reg   <= acc_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= 32'h4000_0000;
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, sq_v_reg} >= sq_sum)
            begin
                sq_v_reg   <= sq_v_reg - sq_sum[31:0];
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.out_store)
        begin
            pend_reg[axis_reg] <= bypass_reg ? raw_reg[axis_reg] : sat_val;
        end
        if (cmd.emit)
        begin
            res_out_reg[0] <= pend_reg[0];
            res_out_reg[1] <= pend_reg[1];
            res_out_reg[2] <= pend_reg[2];
            res_cal_reg    <= done_reg;
            res_mag_reg    <= mag_reg;
            res_scale_reg  <= scale_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_x         = res_out_reg[0];
    assign out_y         = res_out_reg[1];
    assign out_z         = res_out_reg[2];
    assign is_calibrated = res_cal_reg;
    assign gravity_seen  = res_mag_reg;
    assign scale_now     = res_scale_reg;

    `AGSC_ASSERT(a_done_sticky, 1'b1, !$fell(done_reg), "calibration flag dropped")
    `AGSC_ASSERT_NEXT(a_scale_frozen, done_reg, $stable(scale_reg), "scale moved after latch")
    `AGSC_ASSERT(a_collect_after_settle, sample_cnt_reg != 24'd0,
                 settle_cnt_reg >= agsc_pkg::SETTLE_SAMPLES, "samples summed before settling")

endmodule

// ----- src/agsc_ctrl.sv -----
// controller state machine sequencing the datapath
// uses agsc_pkg and the assertion macros
`timescale 1ns / 1ps
`include "accel_gravity_scale_calibrator_defines.svh"

module agsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  agsc_pkg::dp_status_t status,
    output agsc_pkg::dp_cmd_t    cmd
);

    agsc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            agsc_pkg::S_IDLE:      if (in_valid) state_next = agsc_pkg::S_UPD;
            agsc_pkg::S_UPD:       state_next = status.cal_req ? agsc_pkg::S_DIV_START
                                                               : agsc_pkg::S_MUL;
            agsc_pkg::S_DIV_START: state_next = agsc_pkg::S_DIV_WAIT;
            agsc_pkg::S_DIV_WAIT:  if (status.div_done) state_next = agsc_pkg::S_SQR;
            agsc_pkg::S_SQR:       state_next = agsc_pkg::S_ACC;
            agsc_pkg::S_ACC:       state_next = status.last_axis ? agsc_pkg::S_SQRT_INIT
                                                                 : agsc_pkg::S_DIV_START;
            agsc_pkg::S_SQRT_INIT: state_next = agsc_pkg::S_SQRT;
            agsc_pkg::S_SQRT:      if (status.sqrt_done) state_next = agsc_pkg::S_MAG;
            agsc_pkg::S_MAG:       state_next = status.mag_ok ? agsc_pkg::S_SCL_START
                                                              : agsc_pkg::S_MUL;
            agsc_pkg::S_SCL_START: state_next = agsc_pkg::S_SCL_WAIT;
            agsc_pkg::S_SCL_WAIT:  if (status.div_done) state_next = agsc_pkg::S_MUL;
            agsc_pkg::S_MUL:       state_next = agsc_pkg::S_RND;
            agsc_pkg::S_RND:       state_next = status.last_axis ? agsc_pkg::S_EMIT
                                                                 : agsc_pkg::S_MUL;
            agsc_pkg::S_EMIT:      if (!status.res_busy) state_next = agsc_pkg::S_IDLE;
            default:               state_next = agsc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            agsc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            agsc_pkg::S_UPD:       cmd.update = 1'b1;
            agsc_pkg::S_DIV_START: cmd.div_start = 1'b1;
            agsc_pkg::S_SQR:       cmd.mul_sqr = 1'b1;
            agsc_pkg::S_ACC:       cmd.acc_add = 1'b1;
            agsc_pkg::S_SQRT_INIT: cmd.sqrt_init = 1'b1;
            agsc_pkg::S_SQRT:      cmd.sqrt_step = !status.sqrt_done;
            agsc_pkg::S_MAG:       cmd.mag_load = 1'b1;
            agsc_pkg::S_SCL_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_scale = 1'b1;
            end
            agsc_pkg::S_SCL_WAIT:
            begin
                cmd.div_scale  = 1'b1;
                cmd.scale_load = status.div_done;
            end
            agsc_pkg::S_MUL:       cmd.mul_out = 1'b1;
            agsc_pkg::S_RND:       cmd.out_store = 1'b1;
            agsc_pkg::S_EMIT:      cmd.emit = !status.res_busy;
            default:               cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= agsc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `AGSC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken mid-work")

endmodule

// ----- src/accel_gravity_scale_calibrator.sv -----
// channel    | dir | payload
// sample     | in  | accel_x, accel_y, accel_z, ground_speed
// result     | out | out_x, out_y, out_z, is_calibrated, gravity_seen, scale_now
// cfg        | in  | index, data (register write, always ready)
//
// ordinary item: UPD, then MUL and RND per axis, then EMIT; a new sample is accepted only back in IDLE
// calibrating item: the 40-step divider runs three times for the means and, when the magnitude
// check passes, once more for the scale; the square root runs between the two
// reset clears control and calibration state; no clearing pass
// a waiting result does not block the next accept; the emit waits for the result slot
//
// top level: wires the controller, datapath and channel interfaces
// uses agsc_pkg, agsc_if, agsc_ctrl, agsc_dp
`timescale 1ns / 1ps

module accel_gravity_scale_calibrator (
    input  logic          clk,
    input  logic          rst_n,
    agsc_sample_if.sink   sample,
    agsc_result_if.source result,
    agsc_cfg_if.sink      cfg
);

    agsc_pkg::dp_cmd_t    cmd;
    agsc_pkg::dp_status_t status;
    agsc_pkg::cfg_wr_t    cfg_wr;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    agsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    agsc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .accel_x       (sample.accel_x),
        .accel_y       (sample.accel_y),
        .accel_z       (sample.accel_z),
        .ground_speed  (sample.ground_speed),
        .cmd           (cmd),
        .status        (status),
        .res_ready     (result.ready),
        .res_valid     (result.valid),
        .out_x         (result.out_x),
        .out_y         (result.out_y),
        .out_z         (result.out_z),
        .is_calibrated (result.is_calibrated),
        .gravity_seen  (result.gravity_seen),
        .scale_now     (result.scale_now)
    );

endmodule

// ----- sim/tb_accel_gravity_scale_calibrator.sv -----
// self-checking testbench for accel_gravity_scale_calibrator
// predicts every result in place and compares it field by field
// depends on agsc_pkg, agsc_if and the calibrator rtl
`timescale 1ns / 1ps

module tb_accel_gravity_scale_calibrator;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               cal;
        logic [15:0]        grav;
        logic [17:0]        scale;
    } cal_out_t;

    localparam logic [agsc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic clk;
    logic rst_n;

    agsc_sample_if sample ();
    agsc_result_if result ();
    agsc_cfg_if    cfg ();

    accel_gravity_scale_calibrator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // predictor state
    bit          p_bypass;
    bit          p_auto;
    int          p_offs[3];
    int unsigned p_speed_lim;
    int unsigned p_target;
    bit          p_done;
    int unsigned p_settle;
    int unsigned p_count;
    longint      p_sums[3];
    int unsigned p_scale;
    int unsigned p_grav;

    cal_out_t    expected_out[$];
    int          fail_count;
    int          result_count;
    int          item_count;
    bit          idle_on;
    bit          stall_on;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic longint round_mean(longint s, int unsigned n);
        longint unsigned m;
        longint unsigned q;
        m = (s < 0) ? -s : s;
        q = (m + n / 2) / n;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void clear_collection();
        p_settle = 0;
        p_count  = 0;
        for (int i = 0; i < 3; i++)
            p_sums[i] = 0;
    endfunction

    function automatic void try_gravity_fix();
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned s;
        longint          m;
        acc = 0;
        if (p_count == 0)
            return;
        for (int i = 0; i < 3; i++)
        begin
            m = round_mean(p_sums[i], p_count);
            acc += longint'(m * m);
        end
        mag = int_sqrt(acc);
        if (mag > 65535)
            mag = 65535;
        p_grav = 32'(mag);
        if (mag < agsc_pkg::MIN_MAG)
            return;
        s = ((longint'(p_target) << 16) + mag / 2) / mag;
        p_scale = (s > 64'(agsc_pkg::SCALE_MAX)) ? 32'(agsc_pkg::SCALE_MAX) : 32'(s);
        p_done = 1'b1;
        for (int i = 0; i < 3; i++)
            p_sums[i] = 0;
    endfunction

    function automatic void apply_reg(logic [agsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
        case (idx)
            agsc_pkg::REG_BYPASS:   p_bypass = d[0];
            agsc_pkg::REG_AUTO_EN:
            begin
                p_auto = d[0];
                if (!p_auto)
                    clear_collection();
            end
            agsc_pkg::REG_OFFSET_X: p_offs[0] = $signed(d);
            agsc_pkg::REG_OFFSET_Y: p_offs[1] = $signed(d);
            agsc_pkg::REG_OFFSET_Z: p_offs[2] = $signed(d);
            agsc_pkg::REG_SPEED:    p_speed_lim = d;
            agsc_pkg::REG_GRAVITY:  p_target = d[14:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                           logic signed [15:0] az, logic [15:0] spd);
        longint   raw[3];
        longint   v;
        cal_out_t e;
        logic signed [15:0] o[3];
        raw[0] = ax;
        raw[1] = ay;
        raw[2] = az;
        if (p_bypass)
        begin
            for (int i = 0; i < 3; i++)
                o[i] = 16'(raw[i]);
        end
        else
        begin
            if (p_auto && !p_done)
            begin
                if (spd < p_speed_lim)
                begin
                    if (p_settle < 65535)
                        p_settle++;
                    if (p_settle >= agsc_pkg::SETTLE_SAMPLES)
                    begin
                        if (p_count < agsc_pkg::COUNT_MAX)
                        begin
                            for (int i = 0; i < 3; i++)
                                p_sums[i] += raw[i];
                            p_count++;
                        end
                        if (p_count >= agsc_pkg::TARGET_SAMPLES)
                            try_gravity_fix();
                    end
                end
                else if (p_settle > 0)
                    clear_collection();
            end
            for (int i = 0; i < 3; i++)
            begin
                v = raw[i];
                if (p_done)
                    v = (v * longint'(p_scale) + 32768) >>> 16;
                v = v - p_offs[i];
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                o[i] = 16'(v);
            end
        end
        e.x     = o[0];
        e.y     = o[1];
        e.z     = o[2];
        e.cal   = p_done;
        e.grav  = 16'(p_grav);
        e.scale = 18'(p_scale);
        expected_out.insert(expected_out.size(), e);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] rnd_in(int unsigned lo, int unsigned hi);
        return 16'($urandom_range(lo, hi));
    endfunction

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            result.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 99) < 30)
        begin
            result.ready <= 1'b0;
            stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 2);
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            result_count++;
            if (expected_out.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count++;
            end
            else
            begin
                cal_out_t e;
                e = expected_out.pop_front();
                if (result.out_x !== e.x)
                begin
                    $error("out_x expected %0d got %0d", e.x, result.out_x);
                    fail_count++;
                end
                if (result.out_y !== e.y)
                begin
                    $error("out_y expected %0d got %0d", e.y, result.out_y);
                    fail_count++;
                end
                if (result.out_z !== e.z)
                begin
                    $error("out_z expected %0d got %0d", e.z, result.out_z);
                    fail_count++;
                end
                if (result.is_calibrated !== e.cal)
                begin
                    $error("is_calibrated expected %0d got %0d", e.cal, result.is_calibrated);
                    fail_count++;
                end
                if (result.gravity_seen !== e.grav)
                begin
                    $error("gravity_seen expected %0d got %0d", e.grav, result.gravity_seen);
                    fail_count++;
                end
                if (result.scale_now !== e.scale)
                begin
                    $error("scale_now expected %0d got %0d", e.scale, result.scale_now);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] spd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid        <= 1'b1;
        sample.accel_x      <= ax;
        sample.accel_y      <= ay;
        sample.accel_z      <= az;
        sample.ground_speed <= spd;
        do
            @(posedge clk);
        while (!sample.ready);
        predict_sample(ax, ay, az, spd);
        item_count++;
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [agsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        apply_reg(idx, d);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] small_val(int lim);
        return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    task automatic test_directed();
        send_sample(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0001, 16'hFFFF, 16'h7FFF, 16'd127);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'd128);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'd128);
        drain();
        write_reg(agsc_pkg::REG_OFFSET_X, 16'h8000);
        write_reg(agsc_pkg::REG_OFFSET_Y, 16'h7FFF);
        write_reg(agsc_pkg::REG_OFFSET_Z, 16'hFFFF);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'd0);
        send_sample(16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA);
        drain();
        write_reg(agsc_pkg::REG_BYPASS, 16'h0001);
        send_sample(16'h7FFF, 16'h8000, 16'hAAAA, 16'd0);
        send_sample(16'h5555, 16'h0000, 16'hFFFF, 16'h5555);
        drain();
        write_reg(agsc_pkg::REG_BYPASS, 16'h0000);
        write_reg(agsc_pkg::REG_SPEED, 16'hFFFF);
        write_reg(agsc_pkg::REG_GRAVITY, 16'h0001);
        send_sample(16'h0010, 16'h0020, 16'h0030, 16'hFFFE);
        send_sample(16'h0010, 16'h0020, 16'h0030, 16'hFFFF);
        drain();
        write_reg(agsc_pkg::REG_SPEED, 16'h0000);
        send_sample(16'h0010, 16'h0020, 16'h0030, 16'h0000);
        drain();
        write_reg(agsc_pkg::REG_AUTO_EN, 16'h0000);
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0000);
        drain();
        write_reg(agsc_pkg::REG_AUTO_EN, 16'h0001);
        write_reg(agsc_pkg::REG_GRAVITY, 16'h7FFF);
        write_reg(agsc_pkg::REG_OFFSET_X, 16'h0000);
        write_reg(agsc_pkg::REG_OFFSET_Y, 16'h0000);
        write_reg(agsc_pkg::REG_OFFSET_Z, 16'h0000);
    endtask

    // partial collections broken by motion and by disabling auto calibration
    task automatic test_broken_collection();
        drain();
        write_reg(agsc_pkg::REG_SPEED, 16'd1000);
        repeat (66)
            send_sample(small_val(2000), small_val(2000), small_val(2000), rnd_in(0, 999));
        send_sample(rnd16(), rnd16(), rnd16(), rnd_in(1000, 65535));
        repeat (16)
            send_sample(small_val(3000), small_val(3000), small_val(3000),
                        ($urandom_range(0, 9) == 0) ? rnd_in(1000, 65535) : rnd_in(0, 999));
        drain();
        write_reg(agsc_pkg::REG_AUTO_EN, 16'h0000);
        repeat (4)
            send_sample(rnd16(), rnd16(), rnd16(), rnd_in(0, 999));
        drain();
        write_reg(agsc_pkg::REG_AUTO_EN, 16'h0001);
    endtask

    // near-zero mean fails the magnitude check, then a biased run latches the scale
    task automatic test_calibration();
        repeat (300)
            send_sample(small_val(10), small_val(10), small_val(10), rnd_in(0, 999));
        // sender holds off until every result is back
        drain();
        write_reg(agsc_pkg::REG_BYPASS, 16'h0001);
        repeat (6)
            send_sample(rnd16(), rnd16(), rnd16(), rnd16());
        drain();
        write_reg(agsc_pkg::REG_BYPASS, 16'h0000);
        repeat (290)
            send_sample(small_val(10), small_val(10), small_val(10), rnd_in(0, 999));
        while (!p_done)
            send_sample(small_val(10), small_val(10), rnd_in(1500, 3000), rnd_in(0, 999));
    endtask

    task automatic test_calibrated_random();
        int n;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            write_reg(agsc_pkg::REG_OFFSET_X, (phase == 1) ? 16'h8000 : small_val(500));
            write_reg(agsc_pkg::REG_OFFSET_Y, (phase == 1) ? 16'h7FFF : small_val(500));
            write_reg(agsc_pkg::REG_OFFSET_Z, rnd16());
            write_reg(agsc_pkg::REG_BYPASS, (phase == 3) ? 16'h0001 : 16'h0000);
            write_reg(agsc_pkg::REG_SPEED, rnd16());
            idle_on  = (phase != 2);
            stall_on = (phase != 2);
            n = 16;
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_sample(rnd16(), rnd16(), rnd16(), rnd16());
                else
                    send_sample(small_val(9000), small_val(9000), small_val(9000), rnd16());
            end
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        sample.valid        = 1'b0;
        sample.accel_x      = '0;
        sample.accel_y      = '0;
        sample.accel_z      = '0;
        sample.ground_speed = '0;
        cfg.valid           = 1'b0;
        cfg.index           = '0;
        cfg.data            = '0;
        p_bypass            = 1'b0;
        p_auto              = 1'b1;
        p_offs              = '{0, 0, 0};
        p_speed_lim         = agsc_pkg::SPEED_RESET;
        p_target            = agsc_pkg::GRAVITY_RESET;
        p_done              = 1'b0;
        p_scale             = agsc_pkg::SCALE_ONE;
        p_grav              = 0;
        clear_collection();
        fail_count          = 0;
        result_count        = 0;
        item_count          = 0;
        idle_on             = 1'b1;
        stall_on            = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_broken_collection();
        test_calibration();
        test_calibrated_random();
        drain();
        $display("covered %0d items and %0d results: extremes, bypass, offsets,", item_count,
                 result_count);
        $display("broken collections, failed magnitude retries and a saturated scale latch");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/agsc_pkg.sv
src/agsc_if.sv
src/agsc_div.sv
src/agsc_dp.sv
src/agsc_ctrl.sv
src/accel_gravity_scale_calibrator.sv
sim/tb_accel_gravity_scale_calibrator.sv
